// ===== rtl/msw_pkg.sv =====
package msw_pkg;

   // Configuration register map.
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_TARGET = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AIR_TARGET   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIX_TARGET   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SMOOTH_COEFF = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HP_GAIN      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HP_FEEDBACK  = 3'd5;

   // Smoothed gains and the high-pass path live in a 32-bit scaled domain.
   localparam int SCALED_BITS = 32;

   // Widest operand that the shared multiplier sees (the scaled side after widening).
   localparam int MUL_A_BITS = 36;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctl_type;

endpackage

// ===== rtl/msw_if.sv =====
interface msw_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, left_in, right_in, input ready);
   modport sink (input valid, left_in, right_in, output ready);
endinterface

interface msw_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

interface msw_csr_if #(parameter int COEFF_BITS = 16);
   import msw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [COEFF_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/msw_csr.sv =====
module msw_csr #(
   parameter int COEFF_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   msw_csr_if.sink               csr_bus,
   output logic [COEFF_BITS-1:0] width_target,
   output logic [COEFF_BITS-1:0] air_target,
   output logic [COEFF_BITS-1:0] mix_target,
   output logic [COEFF_BITS-1:0] smooth_coeff,
   output logic [COEFF_BITS-1:0] hp_gain,
   output logic [COEFF_BITS-1:0] hp_feedback
);
   import msw_pkg::*;

   localparam logic [COEFF_BITS-1:0] ONE = {1'b1, {(COEFF_BITS-1){1'b0}}};
   localparam logic [COEFF_BITS-1:0] WIDTH_UNITY = {3'b001, {(COEFF_BITS-3){1'b0}}};

   logic [COEFF_BITS-1:0] width_target_ff;
   logic [COEFF_BITS-1:0] air_target_ff;
   logic [COEFF_BITS-1:0] mix_target_ff;
   logic [COEFF_BITS-1:0] smooth_coeff_ff;
   logic [COEFF_BITS-1:0] hp_gain_ff;
   logic [COEFF_BITS-1:0] hp_feedback_ff;

   // Anything written above unity acts as unity.
   function automatic logic [COEFF_BITS-1:0] clamp_one(input logic [COEFF_BITS-1:0] value);
      return (value > ONE) ? ONE : value;
   endfunction

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_target_ff <= WIDTH_UNITY;
         air_target_ff   <= '0;
         mix_target_ff   <= ONE;
         smooth_coeff_ff <= ONE;
         hp_gain_ff      <= '0;
         hp_feedback_ff  <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_WIDTH_TARGET: width_target_ff <= csr_bus.data;
            CSR_AIR_TARGET:   air_target_ff   <= csr_bus.data;
            CSR_MIX_TARGET:   mix_target_ff   <= csr_bus.data;
            CSR_SMOOTH_COEFF: smooth_coeff_ff <= csr_bus.data;
            CSR_HP_GAIN:      hp_gain_ff      <= csr_bus.data;
            CSR_HP_FEEDBACK:  hp_feedback_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign width_target = clamp_one(width_target_ff);
   assign air_target   = clamp_one(air_target_ff);
   assign mix_target   = clamp_one(mix_target_ff);
   assign smooth_coeff = clamp_one(smooth_coeff_ff);
   assign hp_gain      = clamp_one(hp_gain_ff);
   assign hp_feedback  = clamp_one(hp_feedback_ff);

endmodule

// ===== rtl/msw_mac.sv =====
module msw_mac #(
   parameter int A_BITS = 36,
   parameter int B_BITS = 17
) (
   input  logic                           clock,
   input  msw_pkg::mac_ctl_type           ctl,
   input  logic signed [A_BITS-1:0]       op_a,
   input  logic signed [B_BITS-1:0]       op_b,
   output logic signed [A_BITS+B_BITS:0]  acc
);
   import msw_pkg::*;

   localparam int PROD_BITS = A_BITS + B_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;

   // The product is registered; the accumulator takes it in the following cycle.
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      unique case (ctl.acc_op)
         ACC_LOAD: acc_ff <= ACC_BITS'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_BITS'(prod_ff);
         default: ;
      endcase
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/msw_core.sv =====
module msw_core #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   msw_req_if.sink                                       req_bus,
   msw_rsp_if.source                                     rsp_bus,
   input  logic [COEFF_BITS-1:0]                         width_target,
   input  logic [COEFF_BITS-1:0]                         air_target,
   input  logic [COEFF_BITS-1:0]                         mix_target,
   input  logic [COEFF_BITS-1:0]                         smooth_coeff,
   input  logic [COEFF_BITS-1:0]                         hp_gain,
   input  logic [COEFF_BITS-1:0]                         hp_feedback,
   output msw_pkg::mac_ctl_type                          mac_ctl,
   output logic signed [msw_pkg::MUL_A_BITS-1:0]         mac_a,
   output logic signed [COEFF_BITS:0]                    mac_b,
   input  logic signed [msw_pkg::MUL_A_BITS+COEFF_BITS+1:0] mac_acc
);
   import msw_pkg::*;

   localparam int GX        = SCALED_BITS - COEFF_BITS;
   localparam int HX        = SCALED_BITS - SAMPLE_BITS;
   localparam int X_BITS    = SCALED_BITS + 1;
   localparam int SUMH_BITS = SCALED_BITS + 2;
   localparam int OUT_BITS  = MUL_A_BITS + 1;
   localparam int ACC_BITS  = MUL_A_BITS + COEFF_BITS + 2;
   localparam int STEP_BITS = 5;

   localparam logic [COEFF_BITS-1:0]  ONE = {1'b1, {(COEFF_BITS-1){1'b0}}};
   localparam logic [SCALED_BITS-1:0] WIDTH_NOW_RESET = SCALED_BITS'(1) << (SCALED_BITS - 3);
   localparam logic [SCALED_BITS-1:0] MIX_NOW_RESET   = SCALED_BITS'(1) << (SCALED_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] HP_MAX =
      $signed(ACC_BITS'({1'b0, {(SCALED_BITS-1){1'b1}}}));
   localparam logic signed [ACC_BITS-1:0] HP_MIN = -HP_MAX - 1;
   localparam logic signed [OUT_BITS-1:0] OUT_MAX =
      $signed(OUT_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = -OUT_MAX - 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Sequencer steps. A product passes through the product register and then the accumulator before it is read back.
   localparam logic [STEP_BITS-1:0] STEP_HP_IN      = 5'd0;
   localparam logic [STEP_BITS-1:0] STEP_HP_FB      = 5'd1;
   localparam logic [STEP_BITS-1:0] STEP_GAIN_W     = 5'd2;
   localparam logic [STEP_BITS-1:0] STEP_GAIN_A     = 5'd3;
   localparam logic [STEP_BITS-1:0] STEP_GAIN_M     = 5'd4;
   localparam logic [STEP_BITS-1:0] STEP_AIR_WB     = 5'd5;
   localparam logic [STEP_BITS-1:0] STEP_SIDE_RAW   = 5'd6;
   localparam logic [STEP_BITS-1:0] STEP_SIDE_HP    = 5'd7;
   localparam logic [STEP_BITS-1:0] STEP_S1_ADD     = 5'd8;
   localparam logic [STEP_BITS-1:0] STEP_S1_WB      = 5'd9;
   localparam logic [STEP_BITS-1:0] STEP_WIDTH_MUL  = 5'd10;
   localparam logic [STEP_BITS-1:0] STEP_WIDTH_LOAD = 5'd11;
   localparam logic [STEP_BITS-1:0] STEP_WIDTH_WB   = 5'd12;
   localparam logic [STEP_BITS-1:0] STEP_MIX_MUL    = 5'd13;
   localparam logic [STEP_BITS-1:0] STEP_MIX_LOAD   = 5'd14;
   localparam logic [STEP_BITS-1:0] STEP_MIX_WB     = 5'd15;
   localparam logic [STEP_BITS-1:0] STEP_OUT        = 5'd16;

   logic                 state_ff;
   logic [STEP_BITS-1:0] step_ff;

   logic [SCALED_BITS-1:0]        width_now_ff;
   logic [SCALED_BITS-1:0]        air_now_ff;
   logic [SCALED_BITS-1:0]        mix_now_ff;
   logic signed [SAMPLE_BITS-1:0] last_side_ff;
   logic signed [SCALED_BITS-1:0] last_hp_ff;

   logic signed [X_BITS-1:0]      diff_x_ff;
   logic signed [X_BITS-1:0]      dside_x_ff;
   logic signed [SUMH_BITS-1:0]   sumh_ff;
   logic signed [MUL_A_BITS-1:0]  s_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_out_ff;
   logic signed [SAMPLE_BITS-1:0] right_out_ff;
   logic signed [SAMPLE_BITS-1:0] left_out_in;
   logic signed [SAMPLE_BITS-1:0] right_out_in;

   logic                          accept;
   logic                          out_load;
   logic signed [SAMPLE_BITS:0]   diff_lr;
   logic signed [SAMPLE_BITS:0]   sum_lr;
   logic signed [SAMPLE_BITS-1:0] side;
   logic signed [SAMPLE_BITS:0]   dside;

   logic signed [X_BITS-1:0]      dg_width;
   logic signed [X_BITS-1:0]      dg_air;
   logic signed [X_BITS-1:0]      dg_mix;
   logic [COEFF_BITS-1:0]         gain_w;
   logic [COEFF_BITS-1:0]         gain_a;
   logic [COEFF_BITS-1:0]         gain_m;
   logic [COEFF_BITS-1:0]         one_minus_a;
   logic signed [X_BITS-1:0]      hp_twice;

   logic signed [ACC_BITS-1:0]    rnd_unit;
   logic signed [ACC_BITS-1:0]    rnd_width;
   logic [SCALED_BITS-1:0]        gain_step;
   logic signed [SCALED_BITS-1:0] hp_sat;

   logic signed [OUT_BITS-1:0]    left_full;
   logic signed [OUT_BITS-1:0]    right_full;
   logic signed [OUT_BITS-1:0]    left_shift;
   logic signed [OUT_BITS-1:0]    right_shift;

   function automatic logic signed [ACC_BITS-1:0] round_shift(
      input logic signed [ACC_BITS-1:0] value,
      input int unsigned                amount
   );
      return (value + (ACC_BITS'(1) <<< (amount - 1))) >>> amount;
   endfunction

   // Request side.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign diff_lr = (SAMPLE_BITS+1)'(req_bus.left_in) - (SAMPLE_BITS+1)'(req_bus.right_in);
   assign sum_lr  = (SAMPLE_BITS+1)'(req_bus.left_in) + (SAMPLE_BITS+1)'(req_bus.right_in);
   assign side    = diff_lr[SAMPLE_BITS:1];
   assign dside   = (SAMPLE_BITS+1)'(side) - (SAMPLE_BITS+1)'(last_side_ff);

   // Smoother distances and the gains in use.
   assign dg_width = $signed({1'b0, SCALED_BITS'(width_target) << GX}) -
                     $signed({1'b0, width_now_ff});
   assign dg_air   = $signed({1'b0, SCALED_BITS'(air_target) << GX}) -
                     $signed({1'b0, air_now_ff});
   assign dg_mix   = $signed({1'b0, SCALED_BITS'(mix_target) << GX}) -
                     $signed({1'b0, mix_now_ff});
   assign gain_w      = width_now_ff[SCALED_BITS-1:GX];
   assign gain_a      = air_now_ff[SCALED_BITS-1:GX];
   assign gain_m      = mix_now_ff[SCALED_BITS-1:GX];
   assign one_minus_a = ONE - gain_a;
   assign hp_twice    = $signed({last_hp_ff, 1'b0});

   // Results taken back from the accumulator.
   assign rnd_unit  = round_shift(mac_acc, COEFF_BITS - 1);
   assign rnd_width = round_shift(mac_acc, COEFF_BITS - 3);
   assign gain_step = rnd_unit[SCALED_BITS-1:0];
   assign hp_sat    = (rnd_unit > HP_MAX) ? HP_MAX[SCALED_BITS-1:0] :
                      (rnd_unit < HP_MIN) ? HP_MIN[SCALED_BITS-1:0] :
                      rnd_unit[SCALED_BITS-1:0];

   // Multiplier operand selection and accumulator control.
   always_comb begin
      mac_ctl.mul_en = 1'b0;
      mac_ctl.acc_op = ACC_HOLD;
      mac_a          = '0;
      mac_b          = '0;
      if (state_ff == ST_RUN) begin
         unique case (step_ff)
            STEP_HP_IN: begin
               mac_ctl.mul_en = 1'b1;
               mac_a          = MUL_A_BITS'(dside_x_ff);
               mac_b          = $signed({1'b0, hp_gain});
            end
            STEP_HP_FB: begin
               mac_ctl.mul_en = 1'b1;
               mac_ctl.acc_op = ACC_LOAD;
               mac_a          = MUL_A_BITS'(last_hp_ff);
               mac_b          = $signed({1'b0, hp_feedback});
            end
            STEP_GAIN_W: begin
               mac_ctl.mul_en = 1'b1;
               mac_ctl.acc_op = ACC_ADD;
               mac_a          = MUL_A_BITS'(dg_width);
               mac_b          = $signed({1'b0, smooth_coeff});
            end
            STEP_GAIN_A: begin
               mac_ctl.mul_en = 1'b1;
               mac_ctl.acc_op = ACC_LOAD;
               mac_a          = MUL_A_BITS'(dg_air);
               mac_b          = $signed({1'b0, smooth_coeff});
            end
            STEP_GAIN_M: begin
               mac_ctl.mul_en = 1'b1;
               mac_ctl.acc_op = ACC_LOAD;
               mac_a          = MUL_A_BITS'(dg_mix);
               mac_b          = $signed({1'b0, smooth_coeff});
            end
            STEP_AIR_WB: begin
               mac_ctl.acc_op = ACC_LOAD;
            end
            STEP_SIDE_RAW: begin
               mac_ctl.mul_en = 1'b1;
               mac_a          = MUL_A_BITS'(diff_x_ff);
               mac_b          = $signed({1'b0, one_minus_a});
            end
            STEP_SIDE_HP: begin
               mac_ctl.mul_en = 1'b1;
               mac_ctl.acc_op = ACC_LOAD;
               mac_a          = MUL_A_BITS'(hp_twice);
               mac_b          = $signed({1'b0, gain_a});
            end
            STEP_S1_ADD: begin
               mac_ctl.acc_op = ACC_ADD;
            end
            STEP_WIDTH_MUL: begin
               mac_ctl.mul_en = 1'b1;
               mac_a          = s_ff;
               mac_b          = $signed({1'b0, gain_w});
            end
            STEP_WIDTH_LOAD: begin
               mac_ctl.acc_op = ACC_LOAD;
            end
            STEP_MIX_MUL: begin
               mac_ctl.mul_en = 1'b1;
               mac_a          = s_ff;
               mac_b          = $signed({1'b0, gain_m});
            end
            STEP_MIX_LOAD: begin
               mac_ctl.acc_op = ACC_LOAD;
            end
            default: ;
         endcase
      end
   end

   // Final sum and difference, rounded and saturated.
   assign left_full   = OUT_BITS'(sumh_ff) + OUT_BITS'(s_ff);
   assign right_full  = OUT_BITS'(sumh_ff) - OUT_BITS'(s_ff);
   assign left_shift  = left_full >>> (HX + 1);
   assign right_shift = right_full >>> (HX + 1);
   assign left_out_in  = (left_shift > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0] :
                         (left_shift < OUT_MIN) ? OUT_MIN[SAMPLE_BITS-1:0] :
                         left_shift[SAMPLE_BITS-1:0];
   assign right_out_in = (right_shift > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0] :
                         (right_shift < OUT_MIN) ? OUT_MIN[SAMPLE_BITS-1:0] :
                         right_shift[SAMPLE_BITS-1:0];

   // The last step waits until the output register is free.
   assign out_load = (state_ff == ST_RUN) && (step_ff == STEP_OUT) &&
                     (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_now_ff <= WIDTH_NOW_RESET;
         air_now_ff   <= '0;
         mix_now_ff   <= MIX_NOW_RESET;
         last_side_ff <= '0;
         last_hp_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff     <= ST_RUN;
            step_ff      <= STEP_HP_IN;
            last_side_ff <= side;
         end else if (state_ff == ST_RUN) begin
            if (step_ff == STEP_OUT) begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end else begin
               step_ff <= step_ff + STEP_BITS'(1);
            end
            unique case (step_ff)
               STEP_GAIN_A:   last_hp_ff   <= hp_sat;
               STEP_GAIN_M:   width_now_ff <= width_now_ff + gain_step;
               STEP_AIR_WB:   air_now_ff   <= air_now_ff + gain_step;
               STEP_SIDE_RAW: mix_now_ff   <= mix_now_ff + gain_step;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_x_ff  <= X_BITS'(diff_lr) <<< HX;
         dside_x_ff <= X_BITS'(dside) <<< HX;
         sumh_ff    <= (SUMH_BITS'(sum_lr) <<< HX) + (SUMH_BITS'(1) <<< HX);
      end
      if (state_ff == ST_RUN) begin
         unique case (step_ff)
            STEP_S1_WB:    s_ff <= rnd_unit[MUL_A_BITS-1:0];
            STEP_WIDTH_WB: s_ff <= rnd_width[MUL_A_BITS-1:0];
            STEP_MIX_WB:   s_ff <= rnd_unit[MUL_A_BITS-1:0];
            default: ;
         endcase
      end
      if (out_load) begin
         left_out_ff  <= left_out_in;
         right_out_ff <= right_out_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_out_ff;
   assign rsp_bus.right_out = right_out_ff;

endmodule

// ===== rtl/mid_side_stereo_widener.sv =====
// Channel   Direction  Payload                      Transfer
// req_bus   in         left_in, right_in            valid & ready
// rsp_bus   out        left_out, right_out          valid & ready
// csr_bus   in         index, data                  valid & ready (ready always high)
//
// Each accepted request is worked through one shared multiply-accumulate unit,
// which carries all nine products of a frame in sequence.
// A new request is taken only in the cycle after the previous one finishes, so requests are worked one at a time.
// Finished results wait in an output register, so a new request is accepted while the
// previous result is still pending; the last step stalls only if that register is full.
// Synchronous active-high reset restores register defaults, sets the gains to them and
// clears the filter.
module mid_side_stereo_widener #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16
) (
   input logic         clock,
   input logic         reset,
   msw_req_if.sink     req_bus,
   msw_rsp_if.source   rsp_bus,
   msw_csr_if.sink     csr_bus
);
   import msw_pkg::*;

   logic [COEFF_BITS-1:0] width_target;
   logic [COEFF_BITS-1:0] air_target;
   logic [COEFF_BITS-1:0] mix_target;
   logic [COEFF_BITS-1:0] smooth_coeff;
   logic [COEFF_BITS-1:0] hp_gain;
   logic [COEFF_BITS-1:0] hp_feedback;

   mac_ctl_type                          mac_ctl;
   logic signed [MUL_A_BITS-1:0]         mac_a;
   logic signed [COEFF_BITS:0]           mac_b;
   logic signed [MUL_A_BITS+COEFF_BITS+1:0] mac_acc;

   msw_csr #(
      .COEFF_BITS (COEFF_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_bus      (csr_bus),
      .width_target (width_target),
      .air_target   (air_target),
      .mix_target   (mix_target),
      .smooth_coeff (smooth_coeff),
      .hp_gain      (hp_gain),
      .hp_feedback  (hp_feedback)
   );

   msw_mac #(
      .A_BITS (MUL_A_BITS),
      .B_BITS (COEFF_BITS + 1)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   msw_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEFF_BITS  (COEFF_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .width_target (width_target),
      .air_target   (air_target),
      .mix_target   (mix_target),
      .smooth_coeff (smooth_coeff),
      .hp_gain      (hp_gain),
      .hp_feedback  (hp_feedback),
      .mac_ctl      (mac_ctl),
      .mac_a        (mac_a),
      .mac_b        (mac_b),
      .mac_acc      (mac_acc)
   );

endmodule

// ===== bench/msw_checker.sv =====
`timescale 1ns / 1ps

module msw_checker #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_left,
   input  logic signed [SAMPLE_BITS-1:0]          req_right,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0]          rsp_left,
   input  logic signed [SAMPLE_BITS-1:0]          rsp_right,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [msw_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [COEFF_BITS-1:0]                  csr_data,
   output int                                     fail_count,
   output int                                     pending
);
   import msw_pkg::*;

   localparam int     GAIN_EXT    = 32 - COEFF_BITS;
   localparam int     HP_EXT      = 32 - SAMPLE_BITS;
   localparam int     Q_SHIFT     = COEFF_BITS - 1;
   localparam int     WIDTH_SHIFT = COEFF_BITS - 3;
   localparam longint UNITY       = longint'(1) << Q_SHIFT;
   localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN  = -(longint'(1) << (SAMPLE_BITS - 1));
   localparam longint HP_MAX      = 64'sd2147483647;
   localparam longint HP_MIN      = -64'sd2147483648;
   localparam int     NUM_CSRS    = int'(CSR_HP_FEEDBACK) + 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } stereo_type;

   longint     target_reg [NUM_CSRS];
   longint     width_glide;
   longint     air_glide;
   longint     mix_glide;
   longint     prev_side;
   longint     prev_hp;
   stereo_type expected_frames [$];
   int         mismatches = 0;

   // Adds half an LSB and floors, so ties round toward plus infinity.
   function automatic longint rnd_shift(longint value, int shift);
      return (value + (longint'(1) << (shift - 1))) >>> shift;
   endfunction

   function automatic longint clip(longint value, longint lo, longint hi);
      return (value < lo) ? lo : ((value > hi) ? hi : value);
   endfunction

   // Register contents above unity act as unity.
   function automatic longint reg_gain(logic [CSR_IDX_BITS-1:0] index);
      return (target_reg[index] > UNITY) ? UNITY : target_reg[index];
   endfunction

   function automatic longint glide(longint level, longint target, longint coeff);
      return level + rnd_shift(((target <<< GAIN_EXT) - level) * coeff, Q_SHIFT);
   endfunction

   function automatic stereo_type widen_frame(logic signed [SAMPLE_BITS-1:0] left_in,
                                              logic signed [SAMPLE_BITS-1:0] right_in);
      longint     l, r, sum, dif, side, coeff, w, a, m, hp, s1, s2, s3, lo, ro;
      stereo_type frame;
      l     = left_in;
      r     = right_in;
      sum   = l + r;
      dif   = l - r;
      side  = dif >>> 1;
      coeff = reg_gain(CSR_SMOOTH_COEFF);

      width_glide = glide(width_glide, reg_gain(CSR_WIDTH_TARGET), coeff);
      air_glide   = glide(air_glide, reg_gain(CSR_AIR_TARGET), coeff);
      mix_glide   = glide(mix_glide, reg_gain(CSR_MIX_TARGET), coeff);
      w = width_glide >>> GAIN_EXT;
      a = air_glide >>> GAIN_EXT;
      m = mix_glide >>> GAIN_EXT;

      hp = reg_gain(CSR_HP_GAIN) * ((side - prev_side) <<< HP_EXT)
           + reg_gain(CSR_HP_FEEDBACK) * prev_hp;
      hp = clip(rnd_shift(hp, Q_SHIFT), HP_MIN, HP_MAX);
      prev_side = side;
      prev_hp   = hp;

      // The high-passed side already carries the halving, hence the factor two.
      s1 = rnd_shift((dif <<< HP_EXT) * (UNITY - a) + 2 * hp * a, Q_SHIFT);
      s2 = rnd_shift(s1 * w, WIDTH_SHIFT);
      s3 = rnd_shift(s2 * m, Q_SHIFT);

      lo = clip(rnd_shift((sum <<< HP_EXT) + s3, HP_EXT + 1), SAMPLE_MIN, SAMPLE_MAX);
      ro = clip(rnd_shift((sum <<< HP_EXT) - s3, HP_EXT + 1), SAMPLE_MIN, SAMPLE_MAX);
      frame.left  = lo[SAMPLE_BITS-1:0];
      frame.right = ro[SAMPLE_BITS-1:0];
      return frame;
   endfunction

   always @(posedge clock) begin : monitor
      stereo_type got;
      stereo_type want;
      if (reset) begin
         target_reg[CSR_WIDTH_TARGET] = longint'(1) << WIDTH_SHIFT;
         target_reg[CSR_AIR_TARGET]   = 0;
         target_reg[CSR_MIX_TARGET]   = UNITY;
         target_reg[CSR_SMOOTH_COEFF] = UNITY;
         target_reg[CSR_HP_GAIN]      = 0;
         target_reg[CSR_HP_FEEDBACK]  = 0;
         width_glide = target_reg[CSR_WIDTH_TARGET] <<< GAIN_EXT;
         air_glide   = 0;
         mix_glide   = UNITY <<< GAIN_EXT;
         prev_side   = 0;
         prev_hp     = 0;
         expected_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.left  = rsp_left;
            got.right = rsp_right;
            if (expected_frames.size() == 0) begin
               $error("unexpected result: left_out %0d right_out %0d", got.left, got.right);
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               if (got.left !== want.left) begin
                  $error("left_out: expected %0d, actual %0d", want.left, got.left);
                  mismatches++;
               end
               if (got.right !== want.right) begin
                  $error("right_out: expected %0d, actual %0d", want.right, got.right);
                  mismatches++;
               end
            end
         end
         // Writes to indexes past the register map are dropped by the block.
         if (csr_valid && csr_ready && csr_index <= CSR_HP_FEEDBACK) begin
            target_reg[csr_index] = csr_data;
         end
         if (req_valid && req_ready) begin
            expected_frames.push_back(widen_frame(req_left, req_right));
         end
      end
      pending    <= expected_frames.size();
      fail_count <= mismatches;
   end

endmodule

// ===== bench/tb_mid_side_stereo_widener.sv =====
`timescale 1ns / 1ps

module tb_mid_side_stereo_widener;
   import msw_pkg::*;

   localparam int SAMPLE_BITS      = 24;
   localparam int COEFF_BITS       = 16;
   localparam int UNITY            = 1 << (COEFF_BITS - 1);
   localparam int FULL_REG         = (1 << COEFF_BITS) - 1;
   localparam int RANDOM_PHASES    = 8;
   localparam int FRAMES_PER_PHASE = 56;
   localparam int LONG_HOLD        = 300;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 300000;

   localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [CSR_IDX_BITS-1:0]       CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0]       CSR_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   bit   long_hold          = 1'b0;
   int   cycle_count        = 0;
   int   fail_count;
   int   pending;

   msw_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   msw_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   msw_csr_if #(.COEFF_BITS(COEFF_BITS))   csr_bus ();

   mid_side_stereo_widener #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEFF_BITS (COEFF_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   msw_checker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEFF_BITS (COEFF_BITS)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_left  (req_bus.left_in),
      .req_right (req_bus.right_in),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_left  (rsp_bus.left_out),
      .rsp_right (rsp_bus.right_out),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .fail_count(fail_count),
      .pending   (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [COEFF_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l_sample,
                             input logic signed [SAMPLE_BITS-1:0] r_sample);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.left_in  <= l_sample;
      req_bus.right_in <= r_sample;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // The pending count is registered and lags the checker's queue, so always wait for a clock edge before testing it.
   task automatic drain_results();
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int small_value;
      small_value = int'($urandom_range(512)) - 256;
      case ($urandom_range(9))
         0:       return PEAK_POS;
         1:       return PEAK_NEG;
         2:       return small_value[SAMPLE_BITS-1:0];
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COEFF_BITS-1:0] random_reg(logic [CSR_IDX_BITS-1:0] index);
      // Small smoothing steps keep the gains gliding across many frames.
      if (index == CSR_SMOOTH_COEFF) begin
         case ($urandom_range(5))
            0:       return COEFF_BITS'(UNITY);
            1:       return COEFF_BITS'(1);
            default: return COEFF_BITS'($urandom_range(4096, 1));
         endcase
      end
      case ($urandom_range(5))
         0:       return '0;
         1:       return COEFF_BITS'(UNITY);
         2:       return COEFF_BITS'($urandom_range(FULL_REG, UNITY + 1));
         3:       return COEFF_BITS'($urandom_range(FULL_REG));
         default: return COEFF_BITS'($urandom_range(UNITY));
      endcase
   endfunction

   // Response side: random stalls, plus one long hold-off when requested.
   initial begin
      int hold_left;
      bit hold_used;
      hold_left     = 0;
      hold_used     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_used) begin
            hold_left = LONG_HOLD;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic signed [SAMPLE_BITS-1:0] l_sample;
      logic signed [SAMPLE_BITS-1:0] r_sample;
      req_bus.valid    = 1'b0;
      req_bus.left_in  = '0;
      req_bus.right_in = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_WIDTH_TARGET;
      csr_bus.data     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings must reproduce the input exactly.
      send_frame('0, '0);
      send_frame(PEAK_POS, PEAK_POS);
      send_frame(PEAK_NEG, PEAK_NEG);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(SAMPLE_BITS'(-1), '0);
      send_frame(SAMPLE_BITS'(1), SAMPLE_BITS'(-1));
      send_frame(random_sample(), random_sample());
      req_bus.valid <= 1'b0;
      drain_results();

      // Full width, air and feedback: the high-pass state and the outputs saturate.
      write_reg(CSR_WIDTH_TARGET, COEFF_BITS'(UNITY));
      write_reg(CSR_AIR_TARGET, COEFF_BITS'(UNITY));
      write_reg(CSR_MIX_TARGET, COEFF_BITS'(UNITY));
      write_reg(CSR_SMOOTH_COEFF, COEFF_BITS'(UNITY));
      write_reg(CSR_HP_GAIN, COEFF_BITS'(UNITY));
      write_reg(CSR_HP_FEEDBACK, COEFF_BITS'(UNITY));
      csr_bus.valid <= 1'b0;
      repeat (3) begin
         send_frame(PEAK_POS, PEAK_NEG);
         send_frame(PEAK_NEG, PEAK_POS);
      end
      send_frame(PEAK_POS, '0);
      send_frame('0, PEAK_NEG);
      req_bus.valid <= 1'b0;
      drain_results();

      // A zero smoothing step freezes the gains whatever the targets say.
      write_reg(CSR_SMOOTH_COEFF, '0);
      write_reg(CSR_WIDTH_TARGET, COEFF_BITS'(FULL_REG));
      write_reg(CSR_AIR_TARGET, COEFF_BITS'(1));
      write_reg(CSR_MIX_TARGET, '0);
      write_reg(CSR_HP_GAIN, COEFF_BITS'(1));
      write_reg(CSR_HP_FEEDBACK, '0);
      write_reg(CSR_SPARE_A, COEFF_BITS'($urandom));
      write_reg(CSR_SPARE_B, COEFF_BITS'($urandom));
      csr_bus.valid <= 1'b0;
      repeat (4) send_frame(random_sample(), random_sample());
      req_bus.valid <= 1'b0;
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int i = CSR_WIDTH_TARGET; i <= CSR_HP_FEEDBACK; i++) begin
            write_reg(CSR_IDX_BITS'(i), random_reg(CSR_IDX_BITS'(i)));
         end
         if ($urandom_range(1) == 0) begin
            write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, COEFF_BITS'($urandom));
         end
         csr_bus.valid <= 1'b0;

         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct = 68;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 68;
            end
            default: begin
               sender_idle_pct = 37;
               receiver_stall_pct <= 37;
            end
         endcase
         // Results back up while requests keep coming, so the input must stall.
         if (phase == 2) long_hold <= 1'b1;

         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            l_sample = random_sample();
            r_sample = ($urandom_range(3) == 0) ? l_sample : random_sample();
            send_frame(l_sample, r_sample);
         end
         req_bus.valid <= 1'b0;
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
